>>> rtl/base_n_digit_string_parser_defines.svh
// Assertion macros for the base-N digit string parser.
// Needs clk and arst_n in the scope that uses them.
`ifndef BASE_N_DIGIT_STRING_PARSER_DEFINES_SVH
`define BASE_N_DIGIT_STRING_PARSER_DEFINES_SVH

// Condition holds at every edge out of reset.
`define BNDSP_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define BNDSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bndsp_pkg.sv
// Package for the base-N digit string parser: status codes, character
// constants and the digit decode function. No dependencies.
`default_nettype none

package bndsp_pkg;

	localparam int VALUE_W = 64;
	localparam int RADIX_W = 7;
	localparam int WEIGHT_W = 6;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ERROR    = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 7'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 7'd64;
	localparam logic [RADIX_W-1:0] RADIX_ALPHA = 7'd36;
	localparam logic [RADIX_W-1:0] RADIX_FOLD  = 7'd38;

	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_ZERO    = 8'h30;

	// distance from a letter to the slot after the previous group
	localparam logic [7:0] OFF_UPPER      = CH_UPPER_A - CH_NINE - 8'd1;
	localparam logic [7:0] OFF_LOWER_FOLD = CH_LOWER_A - CH_NINE - 8'd1;
	localparam logic [7:0] OFF_LOWER_CASE = (CH_LOWER_A - CH_UPPER_Z - 8'd1) + OFF_UPPER;

	typedef struct packed {
		logic                ok;
		logic [WEIGHT_W-1:0] weight;
	} digit_t;

	function automatic digit_t digit_of(logic [7:0] c, logic [RADIX_W-1:0] b);
		digit_t     r;
		logic [7:0] off;
		logic [7:0] v;
		logic       cls_ok;
		cls_ok = 1'b1;
		off = 8'd0;
		priority if (c >= CH_LOWER_A) begin
			off = (b <= RADIX_FOLD) ? OFF_LOWER_FOLD : OFF_LOWER_CASE;
		end else if (c > CH_UPPER_Z) begin
			cls_ok = 1'b0;
		end else if (c >= CH_UPPER_A) begin
			off = OFF_UPPER;
		end else if (c > CH_NINE) begin
			cls_ok = 1'b0;
		end else begin
			off = 8'd0;
		end
		off = off + ((b > RADIX_ALPHA) ? CH_DOT : CH_ZERO);
		v = c - off;
		r.ok = cls_ok && (c >= off) && (v < {1'b0, b});
		r.weight = v[WEIGHT_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/base_n_digit_string_parser.sv
// Base-N digit string parser: one character per item into a 64-bit value.
// Uses bndsp_pkg and base_n_digit_string_parser_defines.svh.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_stall    | ch[7:0], last
//   out     | output    | out_valid / out_stall  | value[63:0], status[1:0]
//   cfg     | input     | radix_we               | radix[6:0]
//
// One item per cycle while in_stall is low; the result of a last item passes
// the input register, then the result register, before out_valid rises.
// The 64x7 multiply-add on the accumulator sits between the two registers.
// in_stall rises only while a last item waits on a held result.
// arst_n clears valids, accumulator, fault and sets radix to 10.
`default_nettype none

module base_n_digit_string_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        radix_we,
	input  wire logic [6:0]  radix,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  ch,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      value,
	output logic [1:0]       status
);

	localparam int PROD_W = bndsp_pkg::VALUE_W + bndsp_pkg::RADIX_W;

	logic [bndsp_pkg::RADIX_W-1:0] radix_q;
	logic [bndsp_pkg::VALUE_W-1:0] acc_q;
	bndsp_pkg::status_t            fault_q;

	logic       v_s1;
	logic [7:0] ch_s1;
	logic       last_s1;

	logic                          out_valid_q;
	logic [bndsp_pkg::VALUE_W-1:0] value_s2;
	bndsp_pkg::status_t            status_s2;

	logic                          consume;
	logic                          accept;
	logic                          radix_ok;
	bndsp_pkg::digit_t             dig;
	logic [PROD_W-1:0]             prod;
	logic [bndsp_pkg::VALUE_W:0]   sum;
	logic                          mul_ovf;
	logic                          add_ovf;
	bndsp_pkg::status_t            fault_new;
	logic [bndsp_pkg::VALUE_W-1:0] acc_new;

	assign consume  = v_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = v_s1 && !consume;
	assign accept   = in_valid && !in_stall;

	assign radix_ok = (radix_q >= bndsp_pkg::RADIX_MIN) && (radix_q <= bndsp_pkg::RADIX_MAX);
	assign dig      = bndsp_pkg::digit_of(ch_s1, radix_q);
	assign prod     = PROD_W'(acc_q) * PROD_W'(radix_q);
	assign mul_ovf  = |prod[PROD_W-1:bndsp_pkg::VALUE_W];
	assign sum      = {1'b0, prod[bndsp_pkg::VALUE_W-1:0]}
	                + (bndsp_pkg::VALUE_W+1)'(dig.weight);
	assign add_ovf  = sum[bndsp_pkg::VALUE_W];

	always_comb begin
		fault_new = fault_q;
		acc_new = acc_q;
		if (fault_q == bndsp_pkg::ST_OK) begin
			priority if (!radix_ok || !dig.ok) begin
				fault_new = bndsp_pkg::ST_ERROR;
			end else if (mul_ovf || add_ovf) begin
				fault_new = bndsp_pkg::ST_OVERFLOW;
			end else begin
				acc_new = sum[bndsp_pkg::VALUE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= bndsp_pkg::RADIX_RESET;
		end else if (radix_we) begin
			radix_q <= radix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (consume) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1 <= ch;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			fault_q <= bndsp_pkg::ST_OK;
		end else if (consume) begin
			if (last_s1) begin
				acc_q <= '0;
				fault_q <= bndsp_pkg::ST_OK;
			end else begin
				acc_q <= acc_new;
				fault_q <= fault_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			value_s2 <= (fault_new == bndsp_pkg::ST_OK) ? acc_new : '0;
			status_s2 <= fault_new;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_s2;
	assign status    = status_s2;

`include "base_n_digit_string_parser_defines.svh"

	`BNDSP_ASSERT(a_fault_zero_value, !out_valid_q || status_s2 == bndsp_pkg::ST_OK || value_s2 == '0, "faulted result carries nonzero value")
	`BNDSP_ASSERT(a_stall_only_on_held_last, !in_stall || (v_s1 && last_s1 && out_valid_q && out_stall), "input stalled without a blocked last item")
	`BNDSP_ASSERT_NEXT(a_fault_sticky, consume && !last_s1 && fault_q != bndsp_pkg::ST_OK, $stable(fault_q) && $stable(acc_q), "sticky fault or accumulator changed")
	`BNDSP_ASSERT_NEXT(a_last_clears, consume && last_s1, out_valid_q && acc_q == '0 && fault_q == bndsp_pkg::ST_OK, "last item did not emit and clear")

endmodule

`default_nettype wire

>>> sim/base_n_digit_string_parser_tb.sv
// Self-checking testbench for base_n_digit_string_parser: a directed table,
// then random digit strings, checked against an in-bench parsing predictor.
// Depends on bndsp_pkg and the RTL of base_n_digit_string_parser.
`default_nettype none

module base_n_digit_string_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0]        value;
		bndsp_pkg::status_t status;
	} parse_result_t;

	typedef struct packed {
		logic               wr;
		logic [6:0]         rdx;
		logic [7:0]         c;
		logic               l;
		logic               pin;
		logic [63:0]        v;
		bndsp_pkg::status_t st;
	} dir_row_t;

	localparam logic SET = 1'b1, KEEP = 1'b0;
	localparam logic LAST_CH = 1'b1, MID_CH = 1'b0;
	localparam logic PINNED = 1'b1, FREE = 1'b0;
	localparam int DIR_ROWS = 25;
	localparam int RANDOM_ITEMS = 1750;

	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{KEEP, 7'd0,   8'h00, LAST_CH, PINNED, 64'd0,      bndsp_pkg::ST_ERROR},
		'{KEEP, 7'd0,   "0",   LAST_CH, PINNED, 64'd0,      bndsp_pkg::ST_OK},
		'{SET,  7'd36,  "z",   MID_CH,  FREE,   64'd0,      bndsp_pkg::ST_OK},
		'{KEEP, 7'd0,   "Z",   LAST_CH, PINNED, 64'd1295,   bndsp_pkg::ST_OK},
		'{SET,  7'd37,  ".",   MID_CH,  FREE,   64'd0,      bndsp_pkg::ST_OK},
		'{KEEP, 7'd0,   "/",   MID_CH,  FREE,   64'd0,      bndsp_pkg::ST_OK},
		'{KEEP, 7'd0,   "a",   LAST_CH, FREE,   64'd0,      bndsp_pkg::ST_OK},
		'{SET,  7'd64,  "a",   MID_CH,  FREE,   64'd0,      bndsp_pkg::ST_OK},
		'{KEEP, 7'd0,   "Z",   MID_CH,  FREE,   64'd0,      bndsp_pkg::ST_OK},
		'{KEEP, 7'd0,   "/",   LAST_CH, FREE,   64'd0,      bndsp_pkg::ST_OK},
		'{SET,  7'd39,  "a",   LAST_CH, PINNED, 64'd38,     bndsp_pkg::ST_OK},
		'{KEEP, 7'd0,   "b",   LAST_CH, PINNED, 64'd0,      bndsp_pkg::ST_ERROR},
		'{SET,  7'd2,   "1",   MID_CH,  FREE,   64'd0,      bndsp_pkg::ST_OK},
		'{KEEP, 7'd0,   "2",   LAST_CH, PINNED, 64'd0,      bndsp_pkg::ST_ERROR},
		'{SET,  7'd0,   "0",   LAST_CH, PINNED, 64'd0,      bndsp_pkg::ST_ERROR},
		'{SET,  7'd127, "0",   LAST_CH, PINNED, 64'd0,      bndsp_pkg::ST_ERROR},
		'{SET,  7'd65,  ".",   LAST_CH, PINNED, 64'd0,      bndsp_pkg::ST_ERROR},
		'{SET,  7'd10,  8'hFF, LAST_CH, PINNED, 64'd0,      bndsp_pkg::ST_ERROR},
		'{KEEP, 7'd0,   8'h80, MID_CH,  FREE,   64'd0,      bndsp_pkg::ST_OK},
		'{KEEP, 7'd0,   "1",   LAST_CH, PINNED, 64'd0,      bndsp_pkg::ST_ERROR},
		'{KEEP, 7'd0,   "1",   MID_CH,  FREE,   64'd0,      bndsp_pkg::ST_OK},
		'{KEEP, 7'd0,   8'h00, MID_CH,  FREE,   64'd0,      bndsp_pkg::ST_OK},
		'{KEEP, 7'd0,   "2",   LAST_CH, PINNED, 64'd0,      bndsp_pkg::ST_ERROR},
		'{SET,  7'd16,  "f",   MID_CH,  FREE,   64'd0,      bndsp_pkg::ST_OK},
		'{SET,  7'd10,  "9",   LAST_CH, FREE,   64'd0,      bndsp_pkg::ST_OK}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        radix_we = 1'b0;
	logic [6:0]  radix = 7'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  ch = 8'd0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] value;
	logic [1:0]  status;

	// pinned expectation travels with the item
	logic          pin_en = 1'b0;
	parse_result_t pin_result = '0;

	parse_result_t pending_q[$];
	logic [7:0]    text_q[$];
	int            fail_count = 0;
	int            sent_count = 0;
	int            burst_left = 0;
	logic [6:0]    cur_radix = bndsp_pkg::RADIX_RESET;

	logic [6:0]         model_radix = bndsp_pkg::RADIX_RESET;
	logic [63:0]        model_acc = '0;
	bndsp_pkg::status_t model_fault = bndsp_pkg::ST_OK;

	int          stall_tick = 0;
	logic [15:0] stall_pat = '0;

	base_n_digit_string_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.radix_we  (radix_we),
		.radix     (radix),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int weight_of(logic [7:0] c, logic [6:0] b);
		int v;
		v = int'(c);
		if (c >= bndsp_pkg::CH_LOWER_A) begin
			if (b <= bndsp_pkg::RADIX_FOLD)
				v = v - (int'(bndsp_pkg::CH_LOWER_A) - int'(bndsp_pkg::CH_NINE) - 1);
			else
				v = v - (int'(bndsp_pkg::CH_LOWER_A) - int'(bndsp_pkg::CH_UPPER_Z) - 1)
					- (int'(bndsp_pkg::CH_UPPER_A) - int'(bndsp_pkg::CH_NINE) - 1);
		end else if (c > bndsp_pkg::CH_UPPER_Z) begin
			return -1;
		end else if (c >= bndsp_pkg::CH_UPPER_A) begin
			v = v - (int'(bndsp_pkg::CH_UPPER_A) - int'(bndsp_pkg::CH_NINE) - 1);
		end else if (c > bndsp_pkg::CH_NINE) begin
			return -1;
		end
		v = v - ((b > bndsp_pkg::RADIX_ALPHA) ? int'(bndsp_pkg::CH_DOT)
			: int'(bndsp_pkg::CH_ZERO));
		if (v < 0 || v >= int'(b))
			return -1;
		return v;
	endfunction

	// consumes one character; returns 1 when it closes a string
	function automatic logic absorb_char(input logic [7:0] c, input logic l,
			output parse_result_t r);
		int          w;
		logic [70:0] prod;
		logic [64:0] sum;
		if (model_fault == bndsp_pkg::ST_OK) begin
			if (model_radix < bndsp_pkg::RADIX_MIN || model_radix > bndsp_pkg::RADIX_MAX) begin
				model_fault = bndsp_pkg::ST_ERROR;
			end else begin
				w = weight_of(c, model_radix);
				prod = model_acc * model_radix;
				sum = prod[63:0] + w[5:0];
				if (w < 0)
					model_fault = bndsp_pkg::ST_ERROR;
				else if (prod[70:64] != '0 || sum[64])
					model_fault = bndsp_pkg::ST_OVERFLOW;
				else
					model_acc = sum[63:0];
			end
		end
		r.value = (model_fault == bndsp_pkg::ST_OK) ? model_acc : '0;
		r.status = model_fault;
		if (l) begin
			model_acc = '0;
			model_fault = bndsp_pkg::ST_OK;
		end
		return l;
	endfunction

	always @(posedge clk) begin
		parse_result_t exp_r;
		if (arst_n) begin
			if (radix_we)
				model_radix = radix;
			if (in_valid && !in_stall) begin
				if (absorb_char(ch, last, exp_r))
					pending_q = {pending_q, (pin_en ? pin_result : exp_r)};
			end
			if (out_valid && !out_stall) begin
				if (pending_q.size() == 0) begin
					$error("unexpected result: value=%0h status=%0d", value, status);
					fail_count++;
				end else begin
					exp_r = pending_q.pop_front();
					if (value !== exp_r.value) begin
						$error("value: expected %0h, got %0h", exp_r.value, value);
						fail_count++;
					end
					if (status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, status);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		stall_tick = stall_tick + 1;
		if (stall_tick % 96 == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pat = '0;
				1: stall_pat = 16'($urandom & $urandom);
				2: stall_pat = 16'($urandom);
				default: stall_pat = 16'($urandom | $urandom);
			endcase
		end
		out_stall <= stall_pat[stall_tick % 16];
	end

	task automatic send_char(input logic [7:0] c, input logic l, input logic pin,
			input parse_result_t pv);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 8);
		end
		in_valid <= 1'b1;
		ch <= c;
		last <= l;
		pin_en <= pin;
		pin_result <= pv;
		do @(posedge clk); while (in_stall);
		burst_left--;
		sent_count++;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_radix(input logic [6:0] r);
		in_valid <= 1'b0;
		burst_left = 0;
		wait_drained();
		radix_we <= 1'b1;
		radix <= r;
		@(posedge clk);
		radix_we <= 1'b0;
		cur_radix = r;
	endtask

	function automatic logic [6:0] pick_radix();
		case ($urandom_range(0, 9))
			0: return ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 1))
				: 7'($urandom_range(65, 127));
			1: begin
				case ($urandom_range(0, 5))
					0: return bndsp_pkg::RADIX_MIN;
					1: return bndsp_pkg::RADIX_MAX;
					2: return bndsp_pkg::RADIX_ALPHA;
					3: return bndsp_pkg::RADIX_ALPHA + 7'd1;
					4: return bndsp_pkg::RADIX_FOLD;
					default: return bndsp_pkg::RADIX_FOLD + 7'd1;
				endcase
			end
			default: return 7'($urandom_range(2, 64));
		endcase
	endfunction

	function automatic logic [7:0] digit_char(int w, logic [6:0] b);
		logic [7:0] c;
		if (b <= bndsp_pkg::RADIX_ALPHA)
			c = (w < 10) ? 8'(bndsp_pkg::CH_ZERO + w) : 8'(bndsp_pkg::CH_UPPER_A + w - 10);
		else if (w < 12)
			c = 8'(bndsp_pkg::CH_DOT + w);
		else if (w < 38)
			c = 8'(bndsp_pkg::CH_UPPER_A + w - 12);
		else
			c = 8'(bndsp_pkg::CH_LOWER_A + w - 38);
		if (b <= bndsp_pkg::RADIX_FOLD && c >= bndsp_pkg::CH_UPPER_A
				&& $urandom_range(0, 1) == 1)
			c = c + 8'h20;
		return c;
	endfunction

	task automatic make_number(input logic [6:0] b);
		logic [71:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = 72'($urandom_range(0, 2000));
			4, 5, 6: v = {8'd0, $urandom, $urandom} >> $urandom_range(0, 63);
			7, 8: v = 72'h00_FFFF_FFFF_FFFF_FFFF - 72'($urandom_range(0, 500));
			default: v = 72'h01_0000_0000_0000_0000 + 72'($urandom_range(0, 500));
		endcase
		text_q.delete();
		do begin
			text_q.push_front(digit_char(int'(v % b), b));
			v = v / b;
		end while (v != 0);
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3)) text_q.push_front(digit_char(0, b));
	endtask

	initial begin
		int kind;
		int split;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].wr)
				set_radix(DIRECTED[i].rdx);
			send_char(DIRECTED[i].c, DIRECTED[i].l, DIRECTED[i].pin,
				'{DIRECTED[i].v, DIRECTED[i].st});
		end

		while (sent_count < DIR_ROWS + RANDOM_ITEMS) begin
			if ($urandom_range(0, 24) == 0)
				set_radix(pick_radix());
			kind = $urandom_range(0, 19);
			if (cur_radix < bndsp_pkg::RADIX_MIN || cur_radix > bndsp_pkg::RADIX_MAX
					|| kind >= 17) begin
				text_q.delete();
				repeat ($urandom_range(1, 6)) text_q = {text_q, 8'($urandom_range(0, 255))};
			end else if (kind == 16) begin
				text_q.delete();
				text_q = {text_q, 8'h00};
			end else begin
				make_number(cur_radix);
				if (kind >= 14)
					text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
			end
			split = (kind == 13 && text_q.size() > 1) ? $urandom_range(1, text_q.size() - 1)
				: -1;
			foreach (text_q[i]) begin
				if (i == split)
					set_radix(7'($urandom_range(2, 64)));
				send_char(text_q[i], (i == text_q.size() - 1), FREE, '0);
			end
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/bndsp_pkg.sv
rtl/base_n_digit_string_parser.sv
sim/base_n_digit_string_parser_tb.sv
